// File: rtl/base64_stream_encoder_assert.svh
// Assertion macros for the base64 stream encoder.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Check a property outside reset.
`define B64E_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define B64E_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/b64e_pkg.sv
// Shared types, constants and the sextet alphabet of the base64 stream encoder.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  localparam logic [1:0] RegSym62 = 2'd0;
  localparam logic [1:0] RegSym63 = 2'd1;
  localparam logic [1:0] RegPad   = 2'd2;

  localparam logic [1:0] Phase0 = 2'd0;
  localparam logic [1:0] Phase1 = 2'd1;
  localparam logic [1:0] Phase2 = 2'd2;

  localparam logic [7:0] RstSym62 = 8'd45;
  localparam logic [7:0] RstSym63 = 8'd126;
  localparam logic [7:0] RstPad   = 8'd61;

  localparam logic [7:0] CharUpperA = 8'd65;
  localparam logic [7:0] CharLowerA = 8'd97;
  localparam logic [7:0] CharDigit0 = 8'd48;

  localparam logic [5:0] SextetLower = 6'd26;
  localparam logic [5:0] SextetDigit = 6'd52;
  localparam logic [5:0] SextetSym62 = 6'd62;
  localparam logic [5:0] SextetSym63 = 6'd63;

  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } sym_t;

  typedef struct packed {
    logic [1:0]     last_idx;
    sym_t [3:0]     syms;
    logic           last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v,
                                             input logic [7:0] s62,
                                             input logic [7:0] s63);
    logic [7:0] r;
    if (v < SextetLower) begin
      r = CharUpperA + {2'b00, v};
    end else if (v < SextetDigit) begin
      r = CharLowerA + {2'b00, v - SextetLower};
    end else if (v < SextetSym62) begin
      r = CharDigit0 + {2'b00, v - SextetDigit};
    end else if (v == SextetSym62) begin
      r = s62;
    end else begin
      r = s63;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64e_front.sv
// Front end: accepts bytes, tracks the group phase and builds character commands.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            last_byte_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output b64e_pkg::entry_t     entry_o,
  output logic [1:0]           group_phase_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  b64e_pkg::sym_t pad_sym;

  assign in_ready_o    = !full_i;
  assign push_o        = in_valid_i && in_ready_o;
  assign group_phase_o = phase_q;
  assign pad_sym       = '{pad: 1'b1, sextet: 6'd0};

  always_comb begin
    entry_o      = '0;
    entry_o.last = last_byte_i;
    phase_d      = phase_q;
    left_d       = left_q;
    unique case (phase_q)
      b64e_pkg::Phase1: begin
        entry_o.syms[0] = '{pad: 1'b0, sextet: {left_q[1:0], data_byte_i[7:4]}};
        entry_o.syms[1] = '{pad: 1'b0, sextet: {data_byte_i[3:0], 2'b00}};
        entry_o.syms[2] = pad_sym;
        entry_o.last_idx = last_byte_i ? 2'd2 : 2'd0;
        left_d  = data_byte_i[3:0];
        phase_d = b64e_pkg::Phase2;
      end
      b64e_pkg::Phase2: begin
        entry_o.syms[0] = '{pad: 1'b0, sextet: {left_q, data_byte_i[7:6]}};
        entry_o.syms[1] = '{pad: 1'b0, sextet: data_byte_i[5:0]};
        entry_o.last_idx = 2'd1;
        left_d  = 4'd0;
        phase_d = b64e_pkg::Phase0;
      end
      default: begin
        entry_o.syms[0] = '{pad: 1'b0, sextet: data_byte_i[7:2]};
        entry_o.syms[1] = '{pad: 1'b0, sextet: {data_byte_i[1:0], 4'b0000}};
        entry_o.syms[2] = pad_sym;
        entry_o.syms[3] = pad_sym;
        entry_o.last_idx = last_byte_i ? 2'd3 : 2'd0;
        left_d  = {2'b00, data_byte_i[1:0]};
        phase_d = b64e_pkg::Phase1;
      end
    endcase
    if (last_byte_i) begin
      left_d  = 4'd0;
      phase_d = b64e_pkg::Phase0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64e_pkg::Phase0;
      left_q  <= 4'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64e_fifo.sv
// Short command queue between the front end and the character emitter.
`timescale 1ns / 1ps
`default_nettype none

module b64e_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire b64e_pkg::entry_t      entry_i,
  input  wire logic                  pop_i,
  output b64e_pkg::entry_t           head_o,
  output b64e_pkg::fifo_status_t     status_o
);

  b64e_pkg::entry_t mem_q [b64e_pkg::QDepth];
  logic [b64e_pkg::PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [b64e_pkg::CntW-1:0] cnt_q;
  logic do_push, do_pop;

  function automatic logic [b64e_pkg::PtrW-1:0] next_ptr(input logic [b64e_pkg::PtrW-1:0] p);
    return (p == b64e_pkg::PtrW'(b64e_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = (cnt_q == b64e_pkg::CntW'(b64e_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64e_back.sv
// Back end: symbol registers and the character emitter with its output register.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [7:0]            cfg_data_i,
  input  wire b64e_pkg::entry_t      head_i,
  input  wire b64e_pkg::fifo_status_t status_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 char_code_o,
  output logic                       last_char_o
);

  logic [7:0] sym62_q, sym63_q, pad_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] char_q, char_d;
  logic       last_q;
  logic       load, end_of_entry;
  b64e_pkg::sym_t cur_sym;

  assign cfg_ready_o  = 1'b1;
  assign load         = !status_i.empty && (!out_valid_q || out_ready_i);
  assign end_of_entry = (idx_q == head_i.last_idx);
  assign pop_o        = load && end_of_entry;
  assign cur_sym      = head_i.syms[idx_q];
  assign char_d       = cur_sym.pad ? pad_q
                      : b64e_pkg::sextet_char(cur_sym.sextet, sym62_q, sym63_q);

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym62_q <= b64e_pkg::RstSym62;
      sym63_q <= b64e_pkg::RstSym63;
      pad_q   <= b64e_pkg::RstPad;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        b64e_pkg::RegSym62: sym62_q <= cfg_data_i;
        b64e_pkg::RegSym63: sym63_q <= cfg_data_i;
        b64e_pkg::RegPad:   pad_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= end_of_entry ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      last_q <= head_i.last && end_of_entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/base64_stream_encoder.sv
// Top level of the base64 stream encoder: front end, command queue and emitter.
// A byte's first character passes through the queue entry and then the output register.
// Throughput: one character per cycle at the emitter while the queue holds entries and
// out_ready_i is high; a byte yields 1 to 4 characters (4 per 3 bytes sustained).
// The two-entry queue lets bytes be taken while earlier characters still drain.
// Reset (rst_ni low, asynchronous): queue empty, phase 0, symbols '-', '~', '='.
`timescale 1ns / 1ps
`default_nettype none

`include "base64_stream_encoder_assert.svh"

module base64_stream_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      char_code_o,
  output logic            last_char_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  b64e_pkg::entry_t       push_entry, head_entry;
  b64e_pkg::fifo_status_t q_status;
  logic                   push, pop;
  logic [1:0]             group_phase;

  b64e_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .full_i        (q_status.full),
    .push_o        (push),
    .entry_o       (push_entry),
    .group_phase_o (group_phase)
  );

  b64e_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (q_status)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head_entry),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  `B64E_ASSERT(a_last_resets_phase, clk_i, rst_ni, (push && last_byte_i) |=> (group_phase == b64e_pkg::Phase0), "phase not cleared after last byte")
  `B64E_ASSERT_ALWAYS(a_reset_no_output, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")
  `B64E_ASSERT(a_no_invented_item, clk_i, rst_ni, (q_status.empty && !out_valid_o) |=> !out_valid_o, "item emitted from empty queue")

endmodule

`default_nettype wire
